>>> rtl/core/b2b_pkg.sv
// ----------------------------------------------------------------------------
// b2b_pkg
// Shared types, constants and mixing functions for the BLAKE2b hash unit.
// ----------------------------------------------------------------------------
package b2b_pkg;

	localparam int WordW   = 64;
	localparam int LenW    = 7;
	localparam int BufW    = 8;
	localparam int StepW   = 6;
	localparam int NumStep = 48;
	localparam logic [LenW-1:0] DefaultLen = 7'd64;
	localparam logic [63:0] ParamWord = 64'h0000_0000_0101_0000;

	localparam logic [63:0] IV [8] = '{
		64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B, 64'h3C6EF372FE94F82B,
		64'hA54FF53A5F1D36F1, 64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F,
		64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179};

	localparam logic [3:0] SIGMA [12][16] = '{
		'{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
		  4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
		'{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
		  4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
		'{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
		  4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
		'{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
		  4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
		'{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
		  4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
		'{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
		  4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
		'{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
		  4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
		'{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
		  4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
		'{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
		  4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
		'{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
		  4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0},
		'{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
		  4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
		'{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
		  4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3}};

	typedef struct packed {
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] c;
		logic [63:0] d;
	} quad_t;

	typedef struct packed {
		logic            load;       // latch input transaction
		logic            store;      // write held word into block
		logic            pad;        // zero words past the held bytes
		logic            comp_init;  // set up working vector, bump counter
		logic            comp_step;  // one half of four mixing units
		logic            comp_done;  // fold working vector into chain
		logic            final_blk;
		logic [StepW-1:0] step;
		logic            start_msg;  // reload chain for the next message
		logic [2:0]      out_idx;
	} b2b_cmd_t;

	typedef struct packed {
		logic buf_full;
		logic has_bytes;
		logic is_last;
		logic out_last;
	} b2b_stat_t;

	function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
		rotr = (x >> n) | (x << (64 - n));
	endfunction

	// first half of G: rotations 32 and 24; second half: 16 and 63
	function automatic quad_t g_half(input quad_t q, input logic [63:0] m,
		input logic second);
		quad_t r;
		r = q;
		r.a = q.a + q.b + m;
		r.d = second ? rotr(q.d ^ r.a, 16) : rotr(q.d ^ r.a, 32);
		r.c = q.c + r.d;
		r.b = second ? rotr(q.b ^ r.c, 63) : rotr(q.b ^ r.c, 24);
		return r;
	endfunction

endpackage

>>> rtl/core/b2b_ctrl.sv
// ----------------------------------------------------------------------------
// b2b_ctrl
// Sequencer: input intake, compression rounds and digest output.
// ----------------------------------------------------------------------------
module b2b_ctrl import b2b_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	output logic      m_tvalid,
	input  logic      m_tready,
	input  b2b_stat_t stat,
	output b2b_cmd_t  cmd
);

	typedef enum logic [2:0] {
		IDLE, CHECK, STORE, PAD, CINIT, CRUN, CDONE, OUTW
	} state_t;

	state_t           state_q;
	logic [StepW-1:0] step_q;
	logic [2:0]       idx_q;
	logic             final_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			step_q  <= '0;
			idx_q   <= '0;
			final_q <= 1'b0;
		end else begin
			case (state_q)
				IDLE: if (s_tvalid) state_q <= CHECK;
				CHECK: begin
					if (stat.has_bytes && stat.buf_full) begin
						final_q <= 1'b0;
						state_q <= CINIT;
					end else begin
						state_q <= STORE;
					end
				end
				STORE: state_q <= stat.is_last ? PAD : IDLE;
				PAD: begin
					final_q <= 1'b1;
					state_q <= CINIT;
				end
				CINIT: begin
					step_q  <= '0;
					state_q <= CRUN;
				end
				CRUN: begin
					if (step_q == StepW'(NumStep - 1)) state_q <= CDONE;
					else step_q <= step_q + 1'b1;
				end
				CDONE: begin
					idx_q   <= '0;
					state_q <= final_q ? OUTW : STORE;
				end
				OUTW: begin
					if (m_tready) begin
						if (stat.out_last) state_q <= IDLE;
						else idx_q <= idx_q + 1'b1;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == IDLE);
	assign m_tvalid = (state_q == OUTW);

	always_comb begin
		cmd           = '0;
		cmd.load      = (state_q == IDLE) && s_tvalid;
		cmd.store     = (state_q == STORE);
		cmd.pad       = (state_q == PAD);
		cmd.comp_init = (state_q == CINIT);
		cmd.comp_step = (state_q == CRUN);
		cmd.comp_done = (state_q == CDONE);
		cmd.final_blk = final_q;
		cmd.step      = step_q;
		cmd.start_msg = (state_q == OUTW) && m_tready && stat.out_last;
		cmd.out_idx   = idx_q;
	end

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid)) else $error("intake open during output");
	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == CRUN) |-> (step_q < StepW'(NumStep))) else $error("step overrun");
	a_out:  assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(idx_q)))
		else $error("digest word index moved while stalled");

endmodule

>>> rtl/core/b2b_datapath.sv
// ----------------------------------------------------------------------------
// b2b_datapath
// Message block, chain value, byte counter and four shared mixing units.
// ----------------------------------------------------------------------------
module b2b_datapath import b2b_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  b2b_cmd_t        cmd,
	input  logic [63:0]     in_word,
	input  logic [3:0]      in_count,
	input  logic            in_last,
	input  logic            cfg_we,
	input  logic [LenW-1:0] cfg_len,
	output b2b_stat_t       stat,
	output logic [63:0]     out_word,
	output logic [3:0]      out_nbytes
);

	logic [63:0]     chain_q [8];
	logic [63:0]     v_q [16];
	logic [63:0]     msg_q [16];
	logic [127:0]    cnt_q;
	logic [BufW-1:0] buf_q;
	logic [LenW-1:0] len_q, act_q;
	logic [63:0]     word_q;
	logic [3:0]      bcnt_q;
	logic            last_q;

	logic [LenW-1:0] len_clip;
	logic [3:0]      cnt_eff;
	logic [63:0]     word_eff;
	logic [127:0]    cnt_next;
	logic [63:0]     v_next [16];
	logic [4:0]      fill_words;
	logic [LenW-1:0] rem_full;

	always_comb begin
		if (cfg_len == '0) len_clip = LenW'(1);
		else if (cfg_len > DefaultLen) len_clip = DefaultLen;
		else len_clip = cfg_len;
	end

	// short counts only count on the final word
	always_comb begin
		cnt_eff  = (!in_last || in_count > 4'd8) ? 4'd8 : in_count;
		word_eff = in_word;
		if (cnt_eff < 4'd8) word_eff = in_word & ((64'd1 << {cnt_eff, 3'b000}) - 64'd1);
	end

	always_comb begin
		cnt_next = cnt_q + (cmd.final_blk ? 128'(buf_q) : 128'd128);
	end

	assign fill_words = 5'((9'(buf_q) + 9'd7) >> 3);

	// one half-step of four G units, column or diagonal
	always_comb begin
		logic [3:0] rnd;
		logic       diag, second;
		quad_t      q;
		logic [3:0] ia, ib, ic, id;
		rnd    = cmd.step[5:2];
		diag   = cmd.step[1];
		second = cmd.step[0];
		for (int k = 0; k < 16; k++) v_next[k] = v_q[k];
		for (int i = 0; i < 4; i++) begin
			ia = 4'(i);
			ib = diag ? 4'(4 + ((i + 1) % 4)) : 4'(4 + i);
			ic = diag ? 4'(8 + ((i + 2) % 4)) : 4'(8 + i);
			id = diag ? 4'(12 + ((i + 3) % 4)) : 4'(12 + i);
			q = g_half('{a: v_q[ia], b: v_q[ib], c: v_q[ic], d: v_q[id]},
				msg_q[SIGMA[rnd][{diag, 2'(i), second}]], second);
			v_next[ia] = q.a;
			v_next[ib] = q.b;
			v_next[ic] = q.c;
			v_next[id] = q.d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= DefaultLen;
			act_q <= DefaultLen;
			cnt_q <= '0;
			buf_q <= '0;
			for (int i = 1; i < 8; i++) chain_q[i] <= IV[i];
			chain_q[0] <= IV[0] ^ ParamWord ^ 64'(DefaultLen);
		end else begin
			if (cfg_we) begin
				len_q <= len_clip;
				if (buf_q == '0 && cnt_q == '0) begin
					act_q <= len_clip;
					for (int i = 1; i < 8; i++) chain_q[i] <= IV[i];
					chain_q[0] <= IV[0] ^ ParamWord ^ 64'(len_clip);
				end
			end
			if (cmd.comp_init) begin
				cnt_q <= cnt_next;
				if (!cmd.final_blk) buf_q <= '0;
			end
			if (cmd.store && bcnt_q != '0) buf_q <= buf_q + BufW'(bcnt_q);
			if (cmd.comp_done)
				for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] ^ v_q[i] ^ v_q[i+8];
			if (cmd.start_msg) begin
				act_q <= len_q;
				cnt_q <= '0;
				buf_q <= '0;
				for (int i = 1; i < 8; i++) chain_q[i] <= IV[i];
				chain_q[0] <= IV[0] ^ ParamWord ^ 64'(len_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			word_q <= word_eff;
			bcnt_q <= cnt_eff;
			last_q <= in_last;
		end
		if (cmd.store && bcnt_q != '0) msg_q[buf_q[6:3]] <= word_q;
		if (cmd.pad)
			for (int i = 0; i < 16; i++)
				if (5'(i) >= fill_words) msg_q[i] <= '0;
		if (cmd.comp_init) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i]   <= chain_q[i];
				v_q[i+8] <= IV[i];
			end
			v_q[12] <= IV[4] ^ cnt_next[63:0];
			v_q[13] <= IV[5] ^ cnt_next[127:64];
			v_q[14] <= cmd.final_blk ? ~IV[6] : IV[6];
		end
		if (cmd.comp_step)
			for (int k = 0; k < 16; k++) v_q[k] <= v_next[k];
	end

	assign rem_full   = act_q - LenW'({cmd.out_idx, 3'b000});
	assign out_nbytes = (rem_full > LenW'(8)) ? 4'd8 : 4'(rem_full);
	assign out_word   = (out_nbytes == 4'd8) ? chain_q[cmd.out_idx]
		: chain_q[cmd.out_idx] & ((64'd1 << {out_nbytes, 3'b000}) - 64'd1);

	always_comb begin
		stat.buf_full  = buf_q[7];
		stat.has_bytes = (bcnt_q != '0);
		stat.is_last   = last_q;
		stat.out_last  = (rem_full <= LenW'(8));
	end

endmodule

>>> rtl/core/blake2b_hash_unit.sv
// ----------------------------------------------------------------------------
// blake2b_hash_unit
// Unkeyed BLAKE2b (RFC 7693) over a stream of 64-bit message words.
// ----------------------------------------------------------------------------
// One input transaction is taken at a time. A word that only fills the block
// passes IDLE, CHECK and STORE; a word that triggers a compression runs CINIT,
// CRUN and CDONE between CHECK and STORE, the CRUN steps set by one shared set
// of four half-G mixing units running 12 rounds of column and diagonal halves.
// The final word adds a PAD step and a compression, then the digest leaves as
// ceil(len/8) output transactions, one per cycle when the sink is ready.
// ----------------------------------------------------------------------------
module blake2b_hash_unit import b2b_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // [63:0] message_word, [67:64] byte_count, zero fill
	input  logic        s_tlast,   // end_of_message
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // [63:0] digest_word, [67:64] digest_bytes, zero fill
	output logic        m_tlast,   // digest_last
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata  // digest_length
);

	b2b_cmd_t    cmd;
	b2b_stat_t   stat;
	logic [63:0] out_word;
	logic [3:0]  out_nbytes;

	b2b_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready),
		.m_tvalid(m_tvalid), .m_tready(m_tready),
		.stat(stat), .cmd(cmd)
	);

	b2b_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.in_word(s_tdata[63:0]), .in_count(s_tdata[67:64]), .in_last(s_tlast),
		.cfg_we(cfg_we), .cfg_len(cfg_wdata),
		.stat(stat), .out_word(out_word), .out_nbytes(out_nbytes)
	);

	assign m_tdata = {4'd0, out_nbytes, out_word};
	assign m_tlast = stat.out_last;

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the BLAKE2b hash unit. Messages go in as streams of
// 64-bit words with random gaps. A built-in BLAKE2b model predicts each digest
// word, and every output transaction is checked against the oldest prediction.
// The digest length is changed between phases, including its extremes.
// ----------------------------------------------------------------------------
module tb import b2b_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [63:0] word;
		logic [3:0]  cnt;
		logic        eom;
	} msg_item_t;

	typedef struct {
		logic [63:0] word;
		logic [3:0]  nbytes;
		logic        last;
	} digest_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;
	logic        m_tlast;
	logic        cfg_we = 1'b0;
	logic [6:0]  cfg_wdata = '0;

	blake2b_hash_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	msg_item_t    word_q[$];
	digest_item_t digest_q[$];
	int           error_count = 0;
	int           words_sent = 0;
	int           gap_max = 0;
	int           stall_max = 0;
	logic         hold_go = 1'b0;

	// hash state of the model
	logic [63:0] chain_h[8];
	logic [63:0] work_v[16];
	logic [63:0] msg_blk[16];
	logic [63:0] ctr_lo, ctr_hi;
	int unsigned held_bytes;
	int unsigned len_run;
	int unsigned len_reg;

	function automatic logic [63:0] ror64(input logic [63:0] x, input int n);
		return (x >> n) | (x << (64 - n));
	endfunction

	function automatic void g_mix(input int a, input int b, input int c, input int d,
		input logic [63:0] x, input logic [63:0] y);
		work_v[a] = work_v[a] + work_v[b] + x;
		work_v[d] = ror64(work_v[d] ^ work_v[a], 32);
		work_v[c] = work_v[c] + work_v[d];
		work_v[b] = ror64(work_v[b] ^ work_v[c], 24);
		work_v[a] = work_v[a] + work_v[b] + y;
		work_v[d] = ror64(work_v[d] ^ work_v[a], 16);
		work_v[c] = work_v[c] + work_v[d];
		work_v[b] = ror64(work_v[b] ^ work_v[c], 63);
	endfunction

	function automatic void compress_block(input bit fin);
		for (int i = 0; i < 8; i++) begin
			work_v[i] = chain_h[i];
			work_v[i + 8] = IV[i];
		end
		work_v[12] ^= ctr_lo;
		work_v[13] ^= ctr_hi;
		if (fin) begin
			work_v[14] = ~work_v[14];
		end
		for (int r = 0; r < 12; r++) begin
			g_mix(0, 4, 8, 12, msg_blk[SIGMA[r][0]], msg_blk[SIGMA[r][1]]);
			g_mix(1, 5, 9, 13, msg_blk[SIGMA[r][2]], msg_blk[SIGMA[r][3]]);
			g_mix(2, 6, 10, 14, msg_blk[SIGMA[r][4]], msg_blk[SIGMA[r][5]]);
			g_mix(3, 7, 11, 15, msg_blk[SIGMA[r][6]], msg_blk[SIGMA[r][7]]);
			g_mix(0, 5, 10, 15, msg_blk[SIGMA[r][8]], msg_blk[SIGMA[r][9]]);
			g_mix(1, 6, 11, 12, msg_blk[SIGMA[r][10]], msg_blk[SIGMA[r][11]]);
			g_mix(2, 7, 8, 13, msg_blk[SIGMA[r][12]], msg_blk[SIGMA[r][13]]);
			g_mix(3, 4, 9, 14, msg_blk[SIGMA[r][14]], msg_blk[SIGMA[r][15]]);
		end
		for (int i = 0; i < 8; i++) begin
			chain_h[i] ^= work_v[i] ^ work_v[i + 8];
		end
	endfunction

	function automatic void bump_count(input logic [63:0] inc);
		ctr_lo = ctr_lo + inc;
		if (ctr_lo < inc) begin
			ctr_hi = ctr_hi + 64'd1;
		end
	endfunction

	function automatic void restart_hash();
		len_run = len_reg;
		for (int i = 0; i < 8; i++) begin
			chain_h[i] = IV[i];
		end
		chain_h[0] ^= ParamWord | 64'(len_run);
		ctr_lo = '0;
		ctr_hi = '0;
		held_bytes = 0;
	endfunction

	function automatic void set_digest_len(input logic [6:0] v);
		int unsigned len;
		len = v;
		if (len == 0) begin
			len = 1;
		end
		if (len > 64) begin
			len = 64;
		end
		len_reg = len;
		if (held_bytes == 0 && ctr_lo == 0 && ctr_hi == 0) begin
			restart_hash();
		end
	endfunction

	function automatic void absorb_word(input logic [63:0] word_in, input logic [3:0] cnt_in,
		input logic eom);
		logic [63:0]  w;
		int unsigned  cnt;
		int unsigned  n;
		int unsigned  rem;
		digest_item_t d;
		w = word_in;
		cnt = cnt_in;
		if (!eom || cnt > 8) begin
			cnt = 8;
		end
		if (cnt < 8) begin
			w &= (64'd1 << (8 * cnt)) - 64'd1;
		end
		if (cnt > 0) begin
			if (held_bytes >= 128) begin
				bump_count(64'd128);
				compress_block(1'b0);
				held_bytes = 0;
			end
			msg_blk[(held_bytes >> 3) & 15] = w;
			held_bytes += cnt;
		end
		if (!eom) begin
			return;
		end
		for (int i = (held_bytes + 7) >> 3; i < 16; i++) begin
			msg_blk[i] = '0;
		end
		bump_count(64'(held_bytes));
		compress_block(1'b1);
		n = (len_run + 7) >> 3;
		for (int unsigned i = 0; i < n; i++) begin
			rem = len_run - 8 * i;
			if (rem > 8) begin
				rem = 8;
			end
			d.word = chain_h[i];
			if (rem < 8) begin
				d.word &= (64'd1 << (8 * rem)) - 64'd1;
			end
			d.nbytes = 4'(rem);
			d.last = (i + 1 == n);
			digest_q.push_back(d);
		end
		restart_hash();
	endfunction

	// input driver: hold until accepted, then wait the drawn gap
	int gap_left = 0;
	always @(posedge clk) begin
		msg_item_t it;
		if (!(s_tvalid && !s_tready)) begin
			if (gap_left > 0) begin
				s_tvalid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (word_q.size() > 0) begin
				it = word_q.pop_front();
				s_tdata <= {4'b0, it.cnt, it.word};
				s_tlast <= it.eom;
				s_tvalid <= 1'b1;
				gap_left <= $urandom_range(0, gap_max);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// predict on every accepted input transaction
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			absorb_word(s_tdata[63:0], s_tdata[67:64], s_tlast);
		end
	end

	// output ready: random stalls after each transaction, one long hold-off
	int  stall_left = 0;
	int  hold_left = 0;
	logic hold_done = 1'b0;
	always @(posedge clk) begin
		int w;
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= (hold_left == 1);
		end else if (hold_go && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= 400;
			m_tready <= 1'b0;
		end else if (m_tvalid && m_tready) begin
			w = $urandom_range(0, stall_max);
			stall_left <= w;
			m_tready <= (w == 0);
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= (stall_left == 1);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// check each output transaction against the oldest prediction
	always @(posedge clk) begin
		digest_item_t d;
		if (arst_n && m_tvalid && m_tready) begin
			if (digest_q.size() == 0) begin
				$error("unexpected digest word %h", m_tdata[63:0]);
				error_count++;
			end else begin
				d = digest_q.pop_front();
				if (m_tdata[63:0] !== d.word) begin
					$error("digest_word expected %h got %h", d.word, m_tdata[63:0]);
					error_count++;
				end
				if (m_tdata[67:64] !== d.nbytes) begin
					$error("digest_bytes expected %0d got %0d", d.nbytes, m_tdata[67:64]);
					error_count++;
				end
				if (m_tlast !== d.last) begin
					$error("digest_last expected %0d got %0d", d.last, m_tlast);
					error_count++;
				end
			end
		end
	end

	// end the run when nothing moves for too long
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= 3000) begin
			$display("blake2b_hash_unit: mismatch");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic queue_word(input logic [63:0] w, input logic [3:0] c, input logic eom);
		msg_item_t it;
		it.word = w;
		it.cnt = c;
		it.eom = eom;
		word_q.push_back(it);
		words_sent++;
	endtask

	// body words mostly say 8; a few carry a random count that must be ignored
	task automatic queue_message(input int nwords, input logic [3:0] last_cnt);
		for (int i = 0; i < nwords - 1; i++) begin
			queue_word(rand64(), ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'd8, 1'b0);
		end
		queue_word(rand64(), last_cnt, 1'b1);
	endtask

	task automatic drain();
		while (word_q.size() > 0 || s_tvalid || digest_q.size() > 0) begin
			@(posedge clk);
		end
		repeat (80) @(posedge clk);
	endtask

	task automatic write_len(input logic [6:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		set_digest_len(v);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [6:0] len_list[6];
		int         phase;
		len_reg = 64;
		for (int i = 0; i < 16; i++) begin
			msg_blk[i] = '0;
		end
		restart_hash();
		len_list = '{7'd0, 7'd1, 7'd127, 7'd65, 7'd64, 7'd8};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty message, single words, over-long count, full block
		queue_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b1);
		queue_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1);
		queue_word(64'h0123_4567_89AB_CDEF, 4'd15, 1'b1);
		queue_word(rand64(), 4'd3, 1'b0);
		queue_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd5, 1'b1);
		for (int i = 0; i < 16; i++) begin
			queue_word(rand64(), 4'd8, 1'b0);
		end
		queue_word(64'h0, 4'd0, 1'b1);
		drain();

		phase = 0;
		while (phase < 6 || words_sent < 115) begin
			gap_max <= (phase % 3 == 1) ? 0 : 16;
			stall_max <= (phase % 3 == 2) ? 0 : 16;
			write_len((phase < 6) ? len_list[phase] : 7'($urandom));
			if (phase == 2) begin
				hold_go <= 1'b1;
			end
			for (int m = 0; m < 3; m++) begin
				if ($urandom_range(0, 5) == 0) begin
					queue_message($urandom_range(16, 20), 4'($urandom));
				end else begin
					queue_message($urandom_range(1, 5), 4'($urandom));
				end
			end
			drain();
			phase++;
		end

		if (error_count == 0) begin
			$display("blake2b_hash_unit: match");
		end else begin
			$display("blake2b_hash_unit: mismatch");
		end
		$finish;
	end

endmodule
